// ===== rtl/assert_macros.svh =====
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/pwe_pkg.sv =====
// ----------------------------------------------------------------------------
// pwe_pkg
// types and register codes of the pulse waveform evaluator
// ----------------------------------------------------------------------------
package pwe_pkg;

  typedef logic signed [15:0] level_t;
  typedef logic [31:0]        tick_t;

  localparam int unsigned CfgIdxW = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_LOW    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_HIGH   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DELAY  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_RISE   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_WIDTH  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_FALL   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_PERIOD = 3'd6;

  // quotient bits of a ramp division: |diff| * t / ramp < 2^17
  localparam int unsigned QuotW = 17;
  // restoring stages of the period modulo
  localparam int unsigned ModW  = 32;

endpackage

// ===== rtl/pulse_waveform_evaluator_unit.sv =====
// ----------------------------------------------------------------------------
// pulse_waveform_evaluator_unit
// trapezoidal pulse source evaluated at a time given in ticks
// ----------------------------------------------------------------------------
// One level comes out for each time transferred in, one item per clock at full
// rate. One register takes the time past the delay; the period modulo is then
// a 32-stage restoring divider, one remainder bit per stage; three stages walk
// the rise, plateau and fall phases; one stage forms the 16 by 32 bit ramp
// product and 17 more stages divide it by the ramp length, the last of them
// being the output register. A stall holds the whole pipeline. The user must
// write configuration only while no item is in flight; the block itself does
// not enforce it.
`include "assert_macros.svh"

module pulse_waveform_evaluator_unit import pwe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        time_tick_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] level_o
);

  localparam int unsigned DivN = QuotW;

  // configuration registers
  level_t low_q, high_q;
  tick_t  delay_q, rise_q, width_q, fall_q, period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q    <= '0;
      high_q   <= '0;
      delay_q  <= '0;
      rise_q   <= '0;
      width_q  <= '0;
      fall_q   <= '0;
      period_q <= 32'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LOW:    low_q    <= level_t'(cfg_data_i[15:0]);
        REG_HIGH:   high_q   <= level_t'(cfg_data_i[15:0]);
        REG_DELAY:  delay_q  <= cfg_data_i;
        REG_RISE:   rise_q   <= cfg_data_i;
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_FALL:   fall_q   <= cfg_data_i;
        REG_PERIOD: period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // global advance: the pipeline moves when the output is free or taken
  logic adv;
  logic d_vld_q [DivN+1];
  assign adv        = !d_vld_q[DivN] || out_ready_i;
  assign in_ready_o = adv;

  // modulo pipeline, stage 0 holds the elapsed time
  logic  m_vld_q [ModW+1];
  logic  m_low_q [ModW+1];
  tick_t m_rem_q [ModW+1];
  tick_t m_num_q [ModW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= ModW; j++) m_vld_q[j] <= 1'b0;
    end else if (adv) begin
      m_vld_q[0] <= in_valid_i;
      for (int j = 0; j < ModW; j++) m_vld_q[j+1] <= m_vld_q[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_low_q[0] <= time_tick_i < delay_q;
      m_rem_q[0] <= '0;
      m_num_q[0] <= time_tick_i - delay_q;
      for (int j = 0; j < ModW; j++) begin
        logic [32:0] cat;
        cat = {m_rem_q[j], m_num_q[j][31]};
        // a zero period always subtracts zero and leaves the time as it is
        if (cat >= {1'b0, period_q}) m_rem_q[j+1] <= tick_t'(cat - {1'b0, period_q});
        else                         m_rem_q[j+1] <= cat[31:0];
        m_num_q[j+1] <= {m_num_q[j][30:0], 1'b0};
        m_low_q[j+1] <= m_low_q[j];
      end
    end
  end

  // phase walk: rise, plateau, fall
  logic   p_vld_q [3];
  logic   p_done_q[3];
  logic   p_ramp_q[3];
  logic   p_up_q  [3];
  level_t p_lvl_q [3];
  tick_t  p_t_q   [3];

  logic rise_hit, wid_hit, fall_hit;
  assign rise_hit = !m_low_q[ModW] && (m_rem_q[ModW] < rise_q);
  assign wid_hit  = !p_done_q[0] && (p_t_q[0] < width_q);
  assign fall_hit = !p_done_q[1] && (p_t_q[1] < fall_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < 3; j++) p_vld_q[j] <= 1'b0;
    end else if (adv) begin
      p_vld_q[0] <= m_vld_q[ModW];
      p_vld_q[1] <= p_vld_q[0];
      p_vld_q[2] <= p_vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // rise phase check
      p_ramp_q[0] <= rise_hit;
      p_up_q[0]   <= 1'b1;
      p_lvl_q[0]  <= low_q;
      p_t_q[0]    <= rise_hit ? m_rem_q[ModW] : m_rem_q[ModW] - rise_q;
      p_done_q[0] <= m_low_q[ModW] || rise_hit;
      // plateau check
      p_done_q[1] <= p_done_q[0] || wid_hit;
      p_ramp_q[1] <= p_ramp_q[0];
      p_up_q[1]   <= p_up_q[0];
      p_lvl_q[1]  <= wid_hit ? high_q : p_lvl_q[0];
      p_t_q[1]    <= p_done_q[0] ? p_t_q[0] : p_t_q[0] - width_q;
      // fall check, past it the level rests low
      p_done_q[2] <= 1'b1;
      p_ramp_q[2] <= p_ramp_q[1] || fall_hit;
      p_up_q[2]   <= fall_hit ? 1'b0 : p_up_q[1];
      p_lvl_q[2]  <= p_lvl_q[1];
      p_t_q[2]    <= p_t_q[1];
    end
  end

  // ramp product and division pipeline, stage 0 is the product
  logic               d_ramp_q[DivN+1];
  logic               d_up_q  [DivN+1];
  logic               d_neg_q [DivN+1];
  level_t             d_lvl_q [DivN+1];
  tick_t              d_rem_q [DivN+1];
  logic [DivN-1:0]    d_lo_q  [DivN+1];
  logic [DivN-1:0]    d_quo_q [DivN+1];

  level_t      r_from, r_to;
  logic [16:0] r_diff, r_mag;
  logic [47:0] r_prod;

  always_comb begin
    r_from = p_up_q[2] ? low_q  : high_q;
    r_to   = p_up_q[2] ? high_q : low_q;
    r_diff = 17'({r_to[15], r_to} - {r_from[15], r_from});
    r_mag  = r_diff[16] ? 17'(-r_diff) : r_diff;
    r_prod = 48'(r_mag[15:0] * p_t_q[2]) | (r_mag[16] ? {p_t_q[2], 16'd0} : 48'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= DivN; j++) d_vld_q[j] <= 1'b0;
    end else if (adv) begin
      d_vld_q[0] <= p_vld_q[2];
      for (int j = 0; j < DivN; j++) d_vld_q[j+1] <= d_vld_q[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_ramp_q[0] <= p_ramp_q[2];
      d_up_q[0]   <= p_up_q[2];
      d_neg_q[0]  <= r_diff[16];
      d_lvl_q[0]  <= p_ramp_q[2] ? r_from : p_lvl_q[2];
      d_rem_q[0]  <= {1'b0, r_prod[47:DivN]};
      d_lo_q[0]   <= r_prod[DivN-1:0];
      d_quo_q[0]  <= '0;
      for (int j = 0; j < DivN; j++) begin
        logic [32:0] cat;
        tick_t       den;
        cat = {d_rem_q[j], d_lo_q[j][DivN-1]};
        den = d_up_q[j] ? rise_q : fall_q;
        d_ramp_q[j+1] <= d_ramp_q[j];
        d_up_q[j+1]   <= d_up_q[j];
        d_neg_q[j+1]  <= d_neg_q[j];
        d_lvl_q[j+1]  <= d_lvl_q[j];
        d_lo_q[j+1]   <= {d_lo_q[j][DivN-2:0], 1'b0};
        if (cat >= {1'b0, den}) begin
          d_rem_q[j+1] <= tick_t'(cat - {1'b0, den});
          d_quo_q[j+1] <= {d_quo_q[j][DivN-2:0], 1'b1};
        end else begin
          d_rem_q[j+1] <= cat[31:0];
          d_quo_q[j+1] <= {d_quo_q[j][DivN-2:0], 1'b0};
        end
      end
    end
  end

  // final level: start level plus the signed quotient
  logic [17:0] o_sum;
  always_comb begin
    logic [17:0] q_ext;
    q_ext = {1'b0, d_quo_q[DivN]};
    if (d_neg_q[DivN]) q_ext = 18'(-q_ext);
    o_sum = 18'({{2{d_lvl_q[DivN][15]}}, d_lvl_q[DivN]} + q_ext);
  end

  assign out_valid_o = d_vld_q[DivN];
  assign level_o     = d_ramp_q[DivN] ? o_sum[15:0] : d_lvl_q[DivN];

  // checks
  `ASSERT_IMP(a_ready_follows_output, 1'b1, in_ready_o == (!out_valid_o || out_ready_i))
  `ASSERT_IMP(a_mod_rem_below_period, m_vld_q[ModW] && period_q != 0,
              m_rem_q[ModW] < period_q)
  `ASSERT_IMP(a_div_rem_below_den, d_vld_q[DivN] && d_ramp_q[DivN],
              d_rem_q[DivN] < (d_up_q[DivN] ? rise_q : fall_q))
  `ASSERT_NXT(a_stall_holds_pipe, out_valid_o && !out_ready_i,
              out_valid_o && $stable(d_quo_q[DivN]) && $stable(m_vld_q[0]))

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// pulse waveform evaluator testbench
// drives time ticks through several register settings, predicts each level
// from a trapezoidal pulse model and checks the levels in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// expected levels, in order of transfer
class level_scoreboard;
  logic signed [15:0] pending_q[$];
  int                 n_errors;

  logic signed [31:0] lvl_low;
  logic signed [31:0] lvl_high;
  logic [31:0]        t_delay;
  logic [31:0]        t_rise;
  logic [31:0]        t_width;
  logic [31:0]        t_fall;
  logic [31:0]        t_period;

  function new();
    n_errors = 0;
    lvl_low = 0; lvl_high = 0; t_delay = 0; t_rise = 0;
    t_width = 0; t_fall = 0; t_period = 1;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] data);
    case (idx)
      pwe_pkg::REG_LOW:    lvl_low  = 32'($signed(data[15:0]));
      pwe_pkg::REG_HIGH:   lvl_high = 32'($signed(data[15:0]));
      pwe_pkg::REG_DELAY:  t_delay  = data;
      pwe_pkg::REG_RISE:   t_rise   = data;
      pwe_pkg::REG_WIDTH:  t_width  = data;
      pwe_pkg::REG_FALL:   t_fall   = data;
      pwe_pkg::REG_PERIOD: t_period = data;
      default: ;
    endcase
  endfunction

  // linear interpolation, truncated toward zero
  function logic signed [31:0] interp(logic signed [31:0] a, logic signed [31:0] b,
                                      logic [31:0] num, logic [31:0] den);
    longint d;
    longint p;
    d = longint'(b) - longint'(a);
    p = d * longint'({32'd0, num});
    return a + 32'(p / longint'({32'd0, den}));
  endfunction

  function logic signed [15:0] pulse_level(logic [31:0] now);
    logic [31:0] t;
    if (now < t_delay) return lvl_low[15:0];
    t = now - t_delay;
    if (t_period != 0) t = t % t_period;
    if (t < t_rise) return 16'(interp(lvl_low, lvl_high, t, t_rise));
    t -= t_rise;
    if (t < t_width) return lvl_high[15:0];
    t -= t_width;
    if (t < t_fall) return 16'(interp(lvl_high, lvl_low, t, t_fall));
    return lvl_low[15:0];
  endfunction

  function void note_time(logic [31:0] now);
    pending_q.insert(pending_q.size(), pulse_level(now));
  endfunction

  function void check_level(logic signed [15:0] got);
    logic signed [15:0] exp_lvl;
    if (pending_q.size() == 0) begin
      $error("level: unexpected result %0d", got);
      n_errors++;
      return;
    end
    exp_lvl = pending_q.pop_front();
    if (got !== exp_lvl) begin
      $error("level: expected %0d actual %0d", exp_lvl, got);
      n_errors++;
    end
  endfunction
endclass

module tb;
  import pwe_pkg::*;

  localparam int Latency = 54;
  localparam longint CycleLimit = 400000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [31:0]        time_tick_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] level_o;

  level_scoreboard sb = new();
  bit              calm = 1'b0;
  bit              done = 1'b0;
  longint          cycles = 0;

  pulse_waveform_evaluator_unit i_dut (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // output side: random stalls, check each transfer
  initial begin
    int gap;
    while (1) begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_level(level_o);
      if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 13);
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    sb.set_reg(idx, data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_time(logic [31:0] now);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    time_tick_i <= now;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_time(now);
  endtask

  // stop sending and wait for the pipeline to drain
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  task automatic load_setting(logic [15:0] lo, logic [15:0] hi, logic [31:0] dly,
                              logic [31:0] rise, logic [31:0] wid, logic [31:0] fall,
                              logic [31:0] per);
    write_reg(REG_LOW, {{16{lo[15]}}, lo});
    write_reg(REG_HIGH, {{16{hi[15]}}, hi});
    write_reg(REG_DELAY, dly);
    write_reg(REG_RISE, rise);
    write_reg(REG_WIDTH, wid);
    write_reg(REG_FALL, fall);
    write_reg(REG_PERIOD, per);
  endtask

  // time that lands near a phase boundary or anywhere
  function automatic logic [31:0] pick_time();
    logic [31:0] base;
    case ($urandom_range(0, 5))
      0: base = sb.t_delay;
      1: base = sb.t_delay + sb.t_rise;
      2: base = sb.t_delay + sb.t_rise + sb.t_width;
      3: base = sb.t_delay + sb.t_rise + sb.t_width + sb.t_fall;
      4: base = sb.t_delay + sb.t_period * $urandom_range(0, 3);
      default: return $urandom();
    endcase
    return base + $urandom_range(0, 40) - 20;
  endfunction

  // back-to-back transfers, no idling
  task automatic send_burst(logic [31:0] now);
    in_valid_i  <= 1'b1;
    time_tick_i <= now;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_time(now);
  endtask

  // stimulus
  initial begin
    logic [31:0] d;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting
    send_time(32'd0);
    send_time(32'hFFFF_FFFF);
    drain();

    // directed extremes
    load_setting(16'h8000, 16'h7FFF, 32'd10, 32'd7, 32'd3, 32'd5, 32'd20);
    for (int k = 0; k < 14; k++) send_time(32'd8 + k);
    send_time(32'hFFFF_FFFF);
    drain();
    // zero period, zero ramps, phases past the period
    load_setting(16'h7FFF, 16'h8000, 32'd0, 32'd0, 32'd4, 32'd0, 32'd0);
    send_time(32'd0); send_time(32'd3); send_time(32'd4); send_time(32'hFFFF_FFFF);
    drain();
    load_setting(16'd100, 16'hFF00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_time(32'hFFFF_FFFE); send_time(32'hFFFF_FFFF); send_time(32'd0);
    drain();
    // unknown register index must be ignored
    write_reg(3'd7, $urandom());

    // random settings
    for (int s = 0; s < 20; s++) begin
      d = $urandom();
      load_setting(16'($urandom()), 16'($urandom()),
                   ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 100),
                   ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 50),
                   ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 50),
                   ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 50),
                   ($urandom_range(0, 5) == 0) ? d : $urandom_range(0, 200));
      for (int k = 0; k < 50; k++) send_time(pick_time());
      drain();
    end

    // final part without idling
    calm = 1'b1;
    load_setting(16'h8000, 16'h7FFF, 32'd3, 32'd17, 32'd9, 32'd23, 32'd60);
    for (int k = 0; k < 100; k++) send_burst(pick_time());
    drain();
    done = 1'b1;
  end

  // end of run
  initial begin
    wait (done);
    if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pwe_pkg.sv
rtl/pulse_waveform_evaluator_unit.sv
sim/tb.sv
